// ----- sv/rvem_pkg.sv -----
package rvem_pkg;

  // number formats
  localparam int WB = 30;
  localparam int IN_FRAC_BITS = 20;
  localparam int OUT_FRAC_BITS = 22;
  localparam int NORM_FRAC = IN_FRAC_BITS + 8;
  localparam int W_UP = WB - IN_FRAC_BITS;
  localparam int N2_UP = 2 * W_UP;
  localparam int OUT_SH = WB - OUT_FRAC_BITS;

  localparam logic [63:0] ONE = 64'd1 << WB;
  localparam logic [63:0] PI_Q61 = 64'h6487ED5110B4611A;
  localparam logic [63:0] TWO_PI_Q61 = 64'hC90FDAA22168C234;
  localparam logic [63:0] TWO_PI = TWO_PI_Q61 >> (61 - NORM_FRAC);
  localparam logic [63:0] TWO_PI2 = TWO_PI << 1;
  localparam logic [63:0] PI_N = PI_Q61 >> (61 - NORM_FRAC);
  localparam logic [63:0] PI30 = PI_Q61 >> 31;
  localparam logic [63:0] HALF_PI30 = PI_Q61 >> 32;
  localparam logic [63:0] TINY_LIM = 64'd1 << (NORM_FRAC - 4);

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS = 31;
  localparam int HORNER_STEPS = 7;

  // constant divisors, each with floor(2^32 / d)
  localparam logic [63:0] RCP_NUM = 64'd1 << 32;
  localparam logic [9:0] DIV6 = 10'd6;
  localparam logic [9:0] DIV24 = 10'd24;
  localparam logic [9:0] DIV120 = 10'd120;
  localparam logic [9:0] DIV720 = 10'd720;
  localparam logic [31:0] RCP6 = 32'(RCP_NUM / 64'd6);
  localparam logic [31:0] RCP24 = 32'(RCP_NUM / 64'd24);
  localparam logic [31:0] RCP120 = 32'(RCP_NUM / 64'd120);
  localparam logic [31:0] RCP720 = 32'(RCP_NUM / 64'd720);

  // horner steps k = 7 down to 1: sin (2k)(2k+1), cos (2k-1)(2k)
  localparam logic [9:0] SIN_DIV [HORNER_STEPS] =
    '{10'd210, 10'd156, 10'd110, 10'd72, 10'd42, 10'd20, 10'd6};
  localparam logic [9:0] COS_DIV [HORNER_STEPS] =
    '{10'd182, 10'd132, 10'd90, 10'd56, 10'd30, 10'd12, 10'd2};
  localparam logic [31:0] SIN_RCP [HORNER_STEPS] = '{
    32'(RCP_NUM / 64'd210), 32'(RCP_NUM / 64'd156), 32'(RCP_NUM / 64'd110),
    32'(RCP_NUM / 64'd72), 32'(RCP_NUM / 64'd42), 32'(RCP_NUM / 64'd20),
    32'(RCP_NUM / 64'd6)};
  localparam logic [31:0] COS_RCP [HORNER_STEPS] = '{
    32'(RCP_NUM / 64'd182), 32'(RCP_NUM / 64'd132), 32'(RCP_NUM / 64'd90),
    32'(RCP_NUM / 64'd56), 32'(RCP_NUM / 64'd30), 32'(RCP_NUM / 64'd12),
    32'(RCP_NUM / 64'd2)};

  localparam logic signed [37:0] ONE_S = 38'(ONE);
  localparam logic [37:0] RND = (OUT_SH > 0) ? (38'd1 << (OUT_SH - 1)) : 38'd0;

  // word travelling down the cell chains
  typedef struct packed {
    logic [2:0][23:0] p;
    logic [31:0]      cas;
    logic [31:0]      cbs;
    logic [63:0]      v;
    logic [33:0]      rem;
    logic [31:0]      root;
    logic [2:0][31:0] drem;
    logic [2:0][30:0] q;
    logic [31:0]      m;
    logic [31:0]      m2;
    logic [31:0]      hs;
    logic [31:0]      hc;
    logic             sneg;
    logic             cneg;
    logic             tiny;
  } rvem_word_t;

  function automatic logic [23:0] mag24(input logic [23:0] a);
    return a[23] ? (24'd0 - a) : a;
  endfunction

  // quotient estimate, low by at most one
  function automatic logic [31:0] est_div(input logic [31:0] x, input logic [31:0] rcp);
    logic [63:0] pr;
    pr = x * rcp;
    return pr[63:32];
  endfunction

  function automatic logic [31:0] fix_div(input logic [31:0] x, input logic [31:0] q0,
                                          input logic [9:0] d);
    logic [41:0] qd;
    logic [31:0] r;
    qd = q0 * d;
    r = x - qd[31:0];
    return (r >= {22'd0, d}) ? (q0 + 32'd1) : q0;
  endfunction

  // q30 product, truncated toward zero
  function automatic logic signed [35:0] mulq(input logic signed [33:0] a,
                                              input logic signed [33:0] b);
    logic [33:0] ma;
    logic [33:0] mb;
    logic [67:0] pr;
    logic [35:0] r;
    ma = a[33] ? $unsigned(-a) : $unsigned(a);
    mb = b[33] ? $unsigned(-b) : $unsigned(b);
    pr = ma * mb;
    r = pr[65:30];
    return (a[33] ^ b[33]) ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic [23:0] to_out(input logic signed [37:0] a);
    logic signed [37:0] c;
    logic [37:0] u;
    c = (a > ONE_S) ? ONE_S : ((a < -ONE_S) ? -ONE_S : a);
    u = $unsigned(c + ONE_S);
    u = (u + RND) >> OUT_SH;
    return 24'(u - (38'd1 << OUT_FRAC_BITS));
  endfunction

endpackage

// ----- sv/rvem_sqrt_cell.sv -----
module rvem_sqrt_cell import rvem_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_vld,
  input  rvem_word_t in_word,
  output logic       out_vld,
  output rvem_word_t out_word
);

  // one root bit per cell
  rvem_word_t word_next;
  logic [35:0] rem_sh;
  logic [35:0] trial;

  always_comb begin
    word_next = in_word;
    rem_sh = {in_word.rem, in_word.v[63:62]};
    trial = {2'b00, in_word.root, 2'b01};
    word_next.v = {in_word.v[61:0], 2'b00};
    if (rem_sh >= trial) begin
      word_next.rem = 34'(rem_sh - trial);
      word_next.root = {in_word.root[30:0], 1'b1};
    end else begin
      word_next.rem = rem_sh[33:0];
      word_next.root = {in_word.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_word <= word_next;
  end

endmodule

// ----- sv/rvem_div_cell.sv -----
module rvem_div_cell import rvem_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_vld,
  input  rvem_word_t in_word,
  output logic       out_vld,
  output rvem_word_t out_word
);

  // one quotient bit per cell, three lanes sharing the norm as divisor
  rvem_word_t word_next;
  logic [32:0] r2 [3];

  always_comb begin
    word_next = in_word;
    for (int i = 0; i < 3; i++) begin
      r2[i] = {in_word.drem[i], 1'b0};
      if (r2[i] >= {1'b0, in_word.root}) begin
        word_next.drem[i] = 32'(r2[i] - {1'b0, in_word.root});
        word_next.q[i] = {in_word.q[i][29:0], 1'b1};
      end else begin
        word_next.drem[i] = r2[i][31:0];
        word_next.q[i] = {in_word.q[i][29:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_word <= word_next;
  end

endmodule

// ----- sv/rvem_horner_cell.sv -----
module rvem_horner_cell import rvem_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_vld,
  input  rvem_word_t  in_word,
  input  logic [9:0]  sin_div,
  input  logic [31:0] sin_rcp,
  input  logic [9:0]  cos_div,
  input  logic [31:0] cos_rcp,
  output logic        out_vld,
  output rvem_word_t  out_word
);

  // h = one - (m2*h >> 30) / d for the sin and cos lanes, three stages
  logic       vld1;
  logic       vld2;
  rvem_word_t word1;
  rvem_word_t word2;
  rvem_word_t word_next;
  logic [63:0] ps;
  logic [63:0] pc;
  logic [31:0] xs1;
  logic [31:0] xc1;
  logic [31:0] xs2;
  logic [31:0] xc2;
  logic [31:0] es2;
  logic [31:0] ec2;

  assign ps = in_word.m2 * in_word.hs;
  assign pc = in_word.m2 * in_word.hc;

  always_comb begin
    word_next = word2;
    word_next.hs = 32'(ONE) - fix_div(xs2, es2, sin_div);
    word_next.hc = 32'(ONE) - fix_div(xc2, ec2, cos_div);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      vld1 <= in_vld;
      vld2 <= vld1;
      out_vld <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    word1 <= in_word;
    xs1 <= ps[61:30];
    xc1 <= pc[61:30];
    word2 <= word1;
    xs2 <= xs1;
    xc2 <= xc1;
    es2 <= est_div(xs1, sin_rcp);
    ec2 <= est_div(xc1, cos_rcp);
    out_word <= word_next;
  end

endmodule

// ----- sv/rotation_vector_exp_map.sv -----
// rotation vector to rotation matrix (exponential map, rodrigues form)
// input word: phi_x, phi_y, phi_z, signed q3.20 radians, taken at a rising
//   edge where start is high and busy is low; busy is always low, so a new
//   word can be started in every cycle
// result word: r00..r22, the 3x3 matrix in signed q1.22, clamped to +-1,
//   shown for exactly one cycle with done high
// the result of each word is registered through every stage below, and results
//   leave in the order the words came in; throughput one word per cycle
// the work runs down three rows of cells: 32 square-root cells (one root
//   bit each), 31 divider cells (one quotient bit of phi/n each, three
//   lanes) and 7 horner cells (sin and cos polynomial steps, three stages
//   each), with short front and back pipelines around them
// reset clears all valid flags; words in flight are dropped and no result
//   is strobed until a new word has passed through
// the receiver cannot stall, so nothing in the pipeline ever waits
module rotation_vector_exp_map import rvem_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [23:0] phi_x,
  input  logic signed [23:0] phi_y,
  input  logic signed [23:0] phi_z,
  output logic               done,
  output logic signed [23:0] r00,
  output logic signed [23:0] r01,
  output logic signed [23:0] r02,
  output logic signed [23:0] r10,
  output logic signed [23:0] r11,
  output logic signed [23:0] r12,
  output logic signed [23:0] r20,
  output logic signed [23:0] r21,
  output logic signed [23:0] r22
);

  // fully pipelined, never refuses a word
  assign busy = 1'b0;

  // ---------------- front: squares, norm squared, small-angle series
  logic a_vld, b_vld, c_vld, d_vld, e_vld, f_vld, g_vld;
  logic [2:0][23:0] a_p, b_p, c_p, d_p, e_p, f_p;
  logic [2:0][47:0] b_sq;
  logic [47:0] c_s, d_s, e_s, f_s;
  logic [31:0] d_n2, d_e6, d_e24, d_n4;
  logic [31:0] e_d6, e_d24, e_n4, e_e120, e_e720;
  logic [31:0] f_d6, f_d24, f_d120, f_d720;
  logic [95:0] n2_wide;
  logic [31:0] n2;
  logic [63:0] n2_sq;
  rvem_word_t g_next, g_word;

  // n2 = sum of (phi in q30)^2 >> 30, exact from the integer sum
  assign n2_wide = (96'(c_s) << N2_UP) >> WB;
  assign n2 = n2_wide[31:0];
  assign n2_sq = n2 * n2;

  always_comb begin
    g_next = '0;
    g_next.p = f_p;
    // series coefficients, used only for a tiny angle
    g_next.cas = 32'(ONE) - f_d6 + f_d120;
    g_next.cbs = 32'(ONE >> 1) - f_d24 + f_d720;
    g_next.v = {f_s, 16'd0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      d_vld <= 1'b0;
      e_vld <= 1'b0;
      f_vld <= 1'b0;
      g_vld <= 1'b0;
    end else begin
      a_vld <= start & ~busy;
      b_vld <= a_vld;
      c_vld <= b_vld;
      d_vld <= c_vld;
      e_vld <= d_vld;
      f_vld <= e_vld;
      g_vld <= f_vld;
    end
  end

  always_ff @(posedge clk) begin
    a_p <= {phi_z, phi_y, phi_x};
    for (int i = 0; i < 3; i++) begin
      b_sq[i] <= mag24(a_p[i]) * mag24(a_p[i]);
    end
    b_p <= a_p;
    c_s <= b_sq[0] + b_sq[1] + b_sq[2];
    c_p <= b_p;
    d_n2 <= n2;
    d_e6 <= est_div(n2, RCP6);
    d_e24 <= est_div(n2, RCP24);
    d_n4 <= 32'(n2_sq[61:30]);
    d_p <= c_p;
    d_s <= c_s;
    e_d6 <= fix_div(d_n2, d_e6, DIV6);
    e_d24 <= fix_div(d_n2, d_e24, DIV24);
    e_n4 <= d_n4;
    e_e120 <= est_div(d_n4, RCP120);
    e_e720 <= est_div(d_n4, RCP720);
    e_p <= d_p;
    e_s <= d_s;
    f_d6 <= e_d6;
    f_d24 <= e_d24;
    f_d120 <= fix_div(e_n4, e_e120, DIV120);
    f_d720 <= fix_div(e_n4, e_e720, DIV720);
    f_p <= e_p;
    f_s <= e_s;
    g_word <= g_next;
  end

  // ---------------- square-root row: n = floor(sqrt(s * 2^16))
  logic       sq_vld [SQRT_STEPS+1];
  rvem_word_t sq_word [SQRT_STEPS+1];

  assign sq_vld[0] = g_vld;
  assign sq_word[0] = g_word;

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    rvem_sqrt_cell u_sqrt (
      .clk      (clk),
      .rst      (rst),
      .in_vld   (sq_vld[j]),
      .in_word  (sq_word[j]),
      .out_vld  (sq_vld[j+1]),
      .out_word (sq_word[j+1])
    );
  end

  // ---------------- tiny-angle test, first range step, divider setup
  logic       h_vld;
  rvem_word_t h_next, h_word;
  logic [63:0] root64;

  assign root64 = {32'd0, sq_word[SQRT_STEPS].root};

  always_comb begin
    h_next = sq_word[SQRT_STEPS];
    h_next.tiny = root64 < TINY_LIM;
    h_next.m = (root64 >= TWO_PI2) ? 32'(root64 - TWO_PI2) : root64[31:0];
    for (int i = 0; i < 3; i++) begin
      // |phi| << 7 is below n, so the quotient fits 31 bits
      h_next.drem[i] = {1'b0, mag24(sq_word[SQRT_STEPS].p[i]), 7'd0};
      h_next.q[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_vld <= 1'b0;
    end else begin
      h_vld <= sq_vld[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    h_word <= h_next;
  end

  // ---------------- divider row: unit axis = |phi| * 2^38 / n
  logic       dv_vld [DIV_STEPS+1];
  rvem_word_t dv_word [DIV_STEPS+1];

  assign dv_vld[0] = h_vld;
  assign dv_word[0] = h_word;

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    rvem_div_cell u_div (
      .clk      (clk),
      .rst      (rst),
      .in_vld   (dv_vld[j]),
      .in_word  (dv_word[j]),
      .out_vld  (dv_vld[j+1]),
      .out_word (dv_word[j+1])
    );
  end

  // ---------------- angle reduction to [0, pi/2]
  logic       i_vld, j_vld, k_vld, l_vld;
  rvem_word_t i_next, i_word, j_next, j_word, k_next, k_word, l_next, l_word;
  logic [63:0] i_m64, j_m64, k_sh, k_cap;
  logic [63:0] l_sq;

  assign i_m64 = {32'd0, dv_word[DIV_STEPS].m};
  assign j_m64 = {32'd0, i_word.m};
  assign k_sh = (WB >= NORM_FRAC) ? ({32'd0, j_word.m} << (WB - NORM_FRAC))
                                  : ({32'd0, j_word.m} >> (NORM_FRAC - WB));
  assign k_cap = (k_sh > PI30) ? PI30 : k_sh;
  assign l_sq = k_word.m * k_word.m;

  always_comb begin
    // second step of n mod 2pi
    i_next = dv_word[DIV_STEPS];
    i_next.m = (i_m64 >= TWO_PI) ? 32'(i_m64 - TWO_PI) : i_m64[31:0];
    // fold (pi, 2pi) onto (0, pi), sin changes sign
    j_next = i_word;
    j_next.sneg = j_m64 > PI_N;
    j_next.m = (j_m64 > PI_N) ? 32'(TWO_PI - j_m64) : i_word.m;
    // to q30, fold (pi/2, pi] onto [0, pi/2), cos changes sign
    k_next = j_word;
    k_next.cneg = k_cap > HALF_PI30;
    k_next.m = (k_cap > HALF_PI30) ? 32'(PI30 - k_cap) : k_cap[31:0];
    l_next = k_word;
    l_next.m2 = l_sq[61:30];
    l_next.hs = 32'(ONE);
    l_next.hc = 32'(ONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i_vld <= 1'b0;
      j_vld <= 1'b0;
      k_vld <= 1'b0;
      l_vld <= 1'b0;
    end else begin
      i_vld <= dv_vld[DIV_STEPS];
      j_vld <= i_vld;
      k_vld <= j_vld;
      l_vld <= k_vld;
    end
  end

  always_ff @(posedge clk) begin
    i_word <= i_next;
    j_word <= j_next;
    k_word <= k_next;
    l_word <= l_next;
  end

  // ---------------- horner row: sin and cos polynomials side by side
  logic       hn_vld [HORNER_STEPS+1];
  rvem_word_t hn_word [HORNER_STEPS+1];

  assign hn_vld[0] = l_vld;
  assign hn_word[0] = l_word;

  for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_horner
    rvem_horner_cell u_horner (
      .clk      (clk),
      .rst      (rst),
      .in_vld   (hn_vld[j]),
      .in_word  (hn_word[j]),
      .sin_div  (SIN_DIV[j]),
      .sin_rcp  (SIN_RCP[j]),
      .cos_div  (COS_DIV[j]),
      .cos_rcp  (COS_RCP[j]),
      .out_vld  (hn_vld[j+1]),
      .out_word (hn_word[j+1])
    );
  end

  // ---------------- back end: coefficients, products, matrix entries
  logic       m_vld, n_vld, pr_vld, sm_vld, mq_vld, en_vld;
  rvem_word_t m_word;
  logic [63:0] sin_prod;
  logic [31:0] m_sin;
  logic signed [33:0] sin_s, hc_s, cos_v;
  logic signed [33:0] ca_next, cb_next;
  logic signed [33:0] w_next [3];
  logic signed [33:0] qs [3];
  logic signed [33:0] n_ca, n_cb;
  logic signed [33:0] n_w [3];
  logic signed [35:0] pr_xx, pr_yy, pr_zz, pr_xy, pr_xz, pr_yz;
  logic signed [33:0] pr_ca, pr_cb;
  logic signed [33:0] pr_w [3];
  logic signed [36:0] sm_syz, sm_sxz, sm_sxy;
  logic signed [35:0] sm_xy, sm_xz, sm_yz;
  logic signed [33:0] sm_ca, sm_cb;
  logic signed [33:0] sm_w [3];
  logic signed [35:0] mq_d0, mq_d1, mq_d2, mq_bxy, mq_bxz, mq_byz;
  logic signed [35:0] mq_ax, mq_ay, mq_az;
  logic signed [37:0] en [9];

  assign sin_prod = hn_word[HORNER_STEPS].m * hn_word[HORNER_STEPS].hs;

  always_comb begin
    sin_s = $signed({2'b00, m_sin});
    hc_s = 34'($signed(m_word.hc));
    cos_v = m_word.cneg ? -hc_s : hc_s;
    ca_next = m_word.tiny ? $signed({2'b00, m_word.cas})
                          : (m_word.sneg ? -sin_s : sin_s);
    cb_next = m_word.tiny ? $signed({2'b00, m_word.cbs}) : ($signed(34'(ONE)) - cos_v);
    for (int i = 0; i < 3; i++) begin
      qs[i] = $signed({3'b000, m_word.q[i]});
      w_next[i] = m_word.tiny ? (34'($signed(m_word.p[i])) <<< W_UP)
                              : (m_word.p[i][23] ? -qs[i] : qs[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
      n_vld <= 1'b0;
      pr_vld <= 1'b0;
      sm_vld <= 1'b0;
      mq_vld <= 1'b0;
      en_vld <= 1'b0;
      done <= 1'b0;
    end else begin
      m_vld <= hn_vld[HORNER_STEPS];
      n_vld <= m_vld;
      pr_vld <= n_vld;
      sm_vld <= pr_vld;
      mq_vld <= sm_vld;
      en_vld <= mq_vld;
      done <= en_vld;
    end
  end

  always_ff @(posedge clk) begin
    // sin = m * h_sin
    m_word <= hn_word[HORNER_STEPS];
    m_sin <= sin_prod[61:30];
    // rotation coefficients and unit axis
    n_ca <= ca_next;
    n_cb <= cb_next;
    n_w <= w_next;
    // outer product of the axis
    pr_xx <= mulq(n_w[0], n_w[0]);
    pr_yy <= mulq(n_w[1], n_w[1]);
    pr_zz <= mulq(n_w[2], n_w[2]);
    pr_xy <= mulq(n_w[0], n_w[1]);
    pr_xz <= mulq(n_w[0], n_w[2]);
    pr_yz <= mulq(n_w[1], n_w[2]);
    pr_ca <= n_ca;
    pr_cb <= n_cb;
    pr_w <= n_w;
    // diagonal sums
    sm_syz <= 37'(pr_yy) + 37'(pr_zz);
    sm_sxz <= 37'(pr_xx) + 37'(pr_zz);
    sm_sxy <= 37'(pr_xx) + 37'(pr_yy);
    sm_xy <= pr_xy;
    sm_xz <= pr_xz;
    sm_yz <= pr_yz;
    sm_ca <= pr_ca;
    sm_cb <= pr_cb;
    sm_w <= pr_w;
    // scale by the two coefficients
    mq_d0 <= mulq(sm_cb, 34'(sm_syz));
    mq_d1 <= mulq(sm_cb, 34'(sm_sxz));
    mq_d2 <= mulq(sm_cb, 34'(sm_sxy));
    mq_bxy <= mulq(sm_cb, 34'(sm_xy));
    mq_bxz <= mulq(sm_cb, 34'(sm_xz));
    mq_byz <= mulq(sm_cb, 34'(sm_yz));
    mq_ax <= mulq(sm_ca, sm_w[0]);
    mq_ay <= mulq(sm_ca, sm_w[1]);
    mq_az <= mulq(sm_ca, sm_w[2]);
    // entries with the cross-product signs
    en[0] <= ONE_S - 38'(mq_d0);
    en[1] <= 38'(mq_bxy) - 38'(mq_az);
    en[2] <= 38'(mq_bxz) + 38'(mq_ay);
    en[3] <= 38'(mq_bxy) + 38'(mq_az);
    en[4] <= ONE_S - 38'(mq_d1);
    en[5] <= 38'(mq_byz) - 38'(mq_ax);
    en[6] <= 38'(mq_bxz) - 38'(mq_ay);
    en[7] <= 38'(mq_byz) + 38'(mq_ax);
    en[8] <= ONE_S - 38'(mq_d2);
    // clamp and round to the output format
    r00 <= $signed(to_out(en[0]));
    r01 <= $signed(to_out(en[1]));
    r02 <= $signed(to_out(en[2]));
    r10 <= $signed(to_out(en[3]));
    r11 <= $signed(to_out(en[4]));
    r12 <= $signed(to_out(en[5]));
    r20 <= $signed(to_out(en[6]));
    r21 <= $signed(to_out(en[7]));
    r22 <= $signed(to_out(en[8]));
  end

endmodule
